// ----- sv/char_lcd_write_sequencer_defines.svh -----
// Assertion macros for the checker of the LCD write sequencer.
`ifndef CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define CLWS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clws assertion failed");

// Checks that a signal holds its value in the cycle after a condition.
`define CLWS_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("clws assertion failed: value changed while held");

`endif

// ----- sv/clws_pkg.sv -----
package clws_pkg;

  // One input item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       rs_pin;
    logic       en_pin;
    logic [7:0] data_pins;
    logic       ready_res;
    logic       rejected;
  } out_item_t;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_INIT  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_CHAR  = 2'd3;

  // Sequence kinds.
  localparam logic [1:0] SEQ_INIT    = 2'd0;
  localparam logic [1:0] SEQ_CLEAR   = 2'd1;
  localparam logic [1:0] SEQ_NEWLINE = 2'd2;
  localparam logic [1:0] SEQ_DATA    = 2'd3;

  // Phases of one byte write. A sequence position is {step, phase}.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RS    = 3'd1;
  localparam logic [2:0] PH_SETUP = 3'd2;
  localparam logic [2:0] PH_HIGH  = 3'd3;
  localparam logic [2:0] PH_HOLD  = 3'd4;
  localparam logic [2:0] PH_POST  = 3'd5;

  localparam int unsigned POS_W    = 6;
  localparam int unsigned NUM_POS  = 1 << POS_W;

  // Configuration register indexes.
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W  = 5;
  localparam logic [2:0] REG_POWER_UP = 3'd0;
  localparam logic [2:0] REG_CLEAR    = 3'd1;
  localparam logic [2:0] REG_SHORT    = 3'd2;
  localparam logic [2:0] REG_EN_SETUP = 3'd3;
  localparam logic [2:0] REG_EN_HIGH  = 3'd4;
  localparam logic [2:0] REG_EN_HOLD  = 3'd5;

  localparam int unsigned CFG_RESET [NUM_REGS] = '{200000, 2000, 50, 250, 500, 250};

  // Character and command bytes.
  localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME         = 8'h80;
  localparam logic [7:0] CMD_LINE_TWO     = 8'hC0;

  // Number of byte steps in a sequence (init counts its power-up wait as a step).
  function automatic logic [2:0] seq_len(input logic [1:0] kind);
    case (kind)
      SEQ_INIT:  return 3'd5;
      SEQ_CLEAR: return 3'd2;
      default:   return 3'd1;
    endcase
  endfunction

  // True where a position is part of the sequence and can carry a wait.
  function automatic logic pos_valid(input logic [1:0] kind, input logic [POS_W-1:0] pos);
    logic [2:0] ph;
    logic [2:0] st;
    ph = pos[2:0];
    st = pos[5:3];
    case (kind)
      SEQ_INIT: begin
        return ((st == 3'd0) && (ph == PH_POST)) ||
               ((st inside {[3'd1:3'd4]}) && (ph inside {[PH_RS:PH_POST]}));
      end
      SEQ_CLEAR:   return (st inside {[3'd0:3'd1]}) && (ph inside {[PH_RS:PH_POST]});
      SEQ_NEWLINE: return (st == 3'd0) && (ph inside {[PH_RS:PH_POST]});
      default:     return (st == 3'd0) && (ph inside {[PH_RS:PH_HOLD]});
    endcase
  endfunction

  // Register that holds the wait of a position.
  function automatic logic [2:0] wait_reg(input logic [1:0] kind, input logic [POS_W-1:0] pos);
    logic [2:0] ph;
    logic [2:0] st;
    ph = pos[2:0];
    st = pos[5:3];
    case (ph)
      PH_RS:    return REG_SHORT;
      PH_SETUP: return REG_EN_SETUP;
      PH_HIGH:  return REG_EN_HIGH;
      PH_HOLD:  return REG_EN_HOLD;
      default: begin
        case (kind)
          SEQ_INIT: begin
            if (st == 3'd0) return REG_POWER_UP;
            return (st >= 3'd3) ? REG_CLEAR : REG_SHORT;
          end
          SEQ_CLEAR: return (st == 3'd0) ? REG_CLEAR : REG_SHORT;
          default:   return REG_SHORT;
        endcase
      end
    endcase
  endfunction

  // Byte sent at a step of a sequence.
  function automatic logic [7:0] seq_byte(input logic [1:0] kind, input logic [2:0] st,
                                          input logic [7:0] pend);
    case (kind)
      SEQ_INIT: begin
        case (st)
          3'd1:    return CMD_FUNCTION_SET;
          3'd2:    return CMD_DISPLAY_ON;
          3'd3:    return CMD_CLEAR;
          3'd4:    return CMD_HOME;
          default: return 8'h00;
        endcase
      end
      SEQ_CLEAR:   return (st == 3'd0) ? CMD_CLEAR : CMD_HOME;
      SEQ_NEWLINE: return CMD_LINE_TWO;
      default:     return pend;
    endcase
  endfunction

endpackage

// ----- sv/clws_cfg_regs.sv -----
module clws_cfg_regs #(
  parameter int unsigned WAIT_WIDTH = 18
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 psel_i,
  input  logic                                                 penable_i,
  input  logic                                                 pwrite_i,
  input  logic [clws_pkg::PADDR_W-1:0]                         paddr_i,
  input  logic [31:0]                                          pwdata_i,
  output logic [31:0]                                          prdata_o,
  output logic [clws_pkg::NUM_REGS-1:0][WAIT_WIDTH-1:0]        cfg_o
);

  logic [clws_pkg::NUM_REGS-1:0][WAIT_WIDTH-1:0] cfg_q;
  logic [clws_pkg::REG_IDX_W-1:0]                idx;
  logic                                          wr_en;

  assign idx   = paddr_i[clws_pkg::PADDR_W-1:2];
  assign wr_en = psel_i && penable_i && pwrite_i;

  // Register writes in the access cycle of a write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < clws_pkg::NUM_REGS; r++) begin
        cfg_q[r] <= WAIT_WIDTH'(clws_pkg::CFG_RESET[r]);
      end
    end else if (wr_en && (idx < clws_pkg::REG_IDX_W'(clws_pkg::NUM_REGS))) begin
      cfg_q[idx] <= pwdata_i[WAIT_WIDTH-1:0];
    end
  end

  // Read data; unmapped addresses read as zero.
  always_comb begin
    prdata_o = '0;
    if (idx < clws_pkg::REG_IDX_W'(clws_pkg::NUM_REGS)) begin
      prdata_o = 32'(cfg_q[idx]);
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/clws_seq_core.sv -----
module clws_seq_core #(
  parameter int unsigned WAIT_WIDTH = 18
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          step_en_i,
  input  clws_pkg::in_item_t                            item_i,
  input  logic [clws_pkg::NUM_REGS-1:0][WAIT_WIDTH-1:0] cfg_i,
  output clws_pkg::out_item_t                           result_o
);

  localparam int unsigned PW = clws_pkg::POS_W;
  localparam int unsigned NP = clws_pkg::NUM_POS;

  // Sequencer state.
  logic [PW-1:0]         pos_q, pos_d;
  logic [WAIT_WIDTH-1:0] wait_q, wait_d;
  logic [1:0]            kind_q, kind_d;
  logic [7:0]            byte_q, byte_d;
  logic                  rs_q, rs_d;
  logic                  en_q, en_d;
  logic [7:0]            bus_q, bus_d;

  // Step logic.
  logic                          is_tick, busy, start_req, reject, tick_done, search;
  logic [WAIT_WIDTH-1:0]         wait_dec;
  logic [1:0]                    kind_new, kind_eff;
  logic [7:0]                    byte_eff;
  logic [PW-1:0]                 start_pos, cand_pos, end_pos, last_pos;
  logic [clws_pkg::NUM_REGS-1:0] zero_flag;
  logic [NP-1:0]                 valid_mask, cand, low_bit, in_range;
  logic [NP-1:0]                 rs_mask, en_mask;
  logic                          found, rs_hit, en_hit, bus_hit;
  logic [2:0]                    last_phase, last_step, bus_step;
  logic [PW-1:0]                 bus_pos;

  // Waits that are zero are passed within the same step.
  always_comb begin
    for (int r = 0; r < clws_pkg::NUM_REGS; r++) begin
      zero_flag[r] = (cfg_i[r] == '0);
    end
  end

  always_comb begin
    is_tick   = (item_i.kind == clws_pkg::KIND_TICK);
    busy      = (pos_q[2:0] != clws_pkg::PH_IDLE);
    start_req = !is_tick && !busy;
    reject    = !is_tick && busy;
    wait_dec  = wait_q - WAIT_WIDTH'(1);
    tick_done = is_tick && busy && (wait_dec == '0);
    search    = start_req || tick_done;

    // Sequence chosen by a new request.
    case (item_i.kind)
      clws_pkg::KIND_INIT:  kind_new = clws_pkg::SEQ_INIT;
      clws_pkg::KIND_CLEAR: kind_new = clws_pkg::SEQ_CLEAR;
      default: begin
        kind_new = (item_i.char_code == clws_pkg::CHAR_NEWLINE) ?
                   clws_pkg::SEQ_NEWLINE : clws_pkg::SEQ_DATA;
      end
    endcase
    kind_eff = start_req ? kind_new : kind_q;
    byte_eff = (start_req && (item_i.kind == clws_pkg::KIND_CHAR)) ? item_i.char_code : byte_q;

    // A new sequence searches from its start, an expired wait from the next position.
    start_pos = start_req ? '0 : pos_q + PW'(1);

    // Positions of the sequence, and those that would stop with a nonzero wait.
    for (int p = 0; p < NP; p++) begin
      valid_mask[p] = clws_pkg::pos_valid(kind_eff, PW'(p));
      cand[p]       = valid_mask[p] && (PW'(p) >= start_pos) &&
                      !zero_flag[clws_pkg::wait_reg(kind_eff, PW'(p))];
      rs_mask[p]    = (PW'(p) & PW'(7)) == PW'(clws_pkg::PH_RS);
      en_mask[p]    = ((PW'(p) & PW'(7)) == PW'(clws_pkg::PH_SETUP)) ||
                      ((PW'(p) & PW'(7)) == PW'(clws_pkg::PH_HIGH)) ||
                      ((PW'(p) & PW'(7)) == PW'(clws_pkg::PH_HOLD));
    end

    // First position with a wait to run: isolate the lowest set bit and encode it.
    found   = |cand;
    low_bit = cand & (~cand + NP'(1));
    cand_pos = '0;
    for (int p = 0; p < NP; p++) begin
      if (low_bit[p]) cand_pos = cand_pos | PW'(p);
    end

    end_pos  = {clws_pkg::seq_len(kind_eff), clws_pkg::PH_IDLE};
    last_pos = found ? cand_pos : end_pos;

    // Positions entered during this step.
    for (int p = 0; p < NP; p++) begin
      in_range[p] = valid_mask[p] && (PW'(p) >= start_pos) && (PW'(p) <= last_pos);
    end

    last_phase = last_pos[2:0];
    last_step  = last_pos[5:3];
    rs_hit     = |(in_range & rs_mask);
    en_hit     = |(in_range & en_mask);

    // The bus takes the byte of the latest enable setup entered.
    bus_step = ((last_phase == clws_pkg::PH_RS) || (last_phase == clws_pkg::PH_IDLE)) ?
               last_step - 3'd1 : last_step;
    bus_pos  = {bus_step, clws_pkg::PH_SETUP};
    bus_hit  = in_range[bus_pos];

    // Next state.
    pos_d  = pos_q;
    wait_d = wait_q;
    kind_d = kind_eff;
    byte_d = byte_eff;
    rs_d   = rs_q;
    en_d   = en_q;
    bus_d  = bus_q;
    if (search) begin
      pos_d  = found ? cand_pos : '0;
      wait_d = found ? cfg_i[clws_pkg::wait_reg(kind_eff, cand_pos)] : '0;
      if (rs_hit) rs_d = (kind_eff == clws_pkg::SEQ_DATA);
      if (found && (last_phase == clws_pkg::PH_HIGH)) begin
        en_d = 1'b1;
      end else if (en_hit) begin
        en_d = 1'b0;
      end
      if (bus_hit) bus_d = clws_pkg::seq_byte(kind_eff, bus_step, byte_eff);
    end else if (is_tick && busy) begin
      wait_d = wait_dec;
    end

    result_o.rs_pin    = rs_d;
    result_o.en_pin    = en_d;
    result_o.data_pins = bus_d;
    result_o.ready_res = (pos_d[2:0] == clws_pkg::PH_IDLE);
    result_o.rejected  = reject;
  end

  // State update, one item per cycle while step_en_i is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wait_q <= '0;
      kind_q <= '0;
      byte_q <= '0;
      rs_q   <= 1'b0;
      en_q   <= 1'b0;
      bus_q  <= '0;
    end else if (step_en_i) begin
      pos_q  <= pos_d;
      wait_q <= wait_d;
      kind_q <= kind_d;
      byte_q <= byte_d;
      rs_q   <= rs_d;
      en_q   <= en_d;
      bus_q  <= bus_d;
    end
  end

endmodule

// ----- sv/char_lcd_write_sequencer.sv -----
// Character LCD write sequencer for an 8-bit bus: every input transfer (a tick, an init
// request, a clear-and-home request or a character) yields exactly one result transfer
// with the RS, EN and data pin levels, a ready flag and a rejected flag. The block takes
// one item per clock cycle while the input is not stalled. An item passes an input
// register and then a result register before its result is offered. A stalled result
// holds the input register, and the input stalls only while both registers are full.
// The sequencer state is updated in a single pass per item, so back-to-back ticks count
// the waits exactly. Zero-length waits are skipped within the same item by a search over
// the positions of the running sequence. The six wait registers sit on the APB port at
// byte addresses 0 to 20 and should be written only while no request is in progress.
module char_lcd_write_sequencer #(
  parameter int unsigned WAIT_WIDTH = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  clws_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output clws_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clws_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [clws_pkg::NUM_REGS-1:0][WAIT_WIDTH-1:0] cfg;
  clws_pkg::in_item_t  in_q;
  clws_pkg::out_item_t out_q, result;
  logic                in_valid_q, out_valid_q, out_free, proc, in_take;

  assign pready = 1'b1;

  clws_cfg_regs #(
    .WAIT_WIDTH(WAIT_WIDTH)
  ) u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Pipeline control: the input register moves on whenever the result register frees up.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  clws_seq_core #(
    .WAIT_WIDTH(WAIT_WIDTH)
  ) u_seq_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (proc),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/clws_checker.sv -----
`include "char_lcd_write_sequencer_defines.svh"

module clws_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input clws_pkg::out_item_t out_data_i
);

  // A stalled result stays offered and unchanged.
  `CLWS_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)
  `CLWS_ASSERT_HOLD(a_out_data_holds, clk_i, rst_ni, out_valid_i && out_stall_i, out_data_i)

  // The input side only waits on a stalled result.
  `CLWS_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_i |-> out_valid_i && out_stall_i)

  // A dropped request leaves the sequence running.
  `CLWS_ASSERT(a_reject_busy, clk_i, rst_ni, out_valid_i && out_data_i.rejected |-> !out_data_i.ready_res)

  // The enable strobe is high only in the middle of a byte write.
  `CLWS_ASSERT(a_en_busy, clk_i, rst_ni, out_valid_i && out_data_i.en_pin |-> !out_data_i.ready_res)

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
